/* hdl/heading_rotation_pid_top_assert.svh */
// Assertion macros used by the heading rotation PID design.
`ifndef HEADING_ROTATION_PID_TOP_ASSERT_SVH
`define HEADING_ROTATION_PID_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define HRP_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define HRP_ASSERT_NXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define HRP_ASSERT_IMP(name, ck, rs, ante, cons)
`define HRP_ASSERT_NXT(name, ck, rs, ante, cons)

`endif

`endif

/* hdl/hrp_pkg.sv */
// Types, widths and constants of the heading rotation PID controller.
package hrp_pkg;

  // Fixed-point formats
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int GAIN_FRAC_BITS  = 8;

  // Field and state widths
  localparam int YAW_W   = 16;
  localparam int GOAL_W  = 17;
  localparam int ERR_W   = 18;
  localparam int SUM_W   = 32;
  localparam int GAIN_W  = 16;
  localparam int THR_W   = 15;
  localparam int SPEED_W = 18;
  localparam int ACC_W   = 52;

  // Stream widths
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 1;

  // APB port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Pi in angle units, rounded to nearest from a Q20 value
  localparam int PI_Q20    = 3294199;
  localparam int ANGLE_PI  = (((PI_Q20 * 2) >> (20 - ANGLE_FRAC_BITS)) + 1) >> 1;
  localparam int ANGLE_2PI = 2 * ANGLE_PI;

  // Register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST      = GAIN_W'(128);
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST     = GAIN_W'(0);
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST     = GAIN_W'(0);
  localparam logic [THR_W-1:0]  STOP_THRESHOLD_RST = THR_W'(1430);

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_PROP_GAIN      = 2'd0,
    REG_INTEG_GAIN     = 2'd1,
    REG_DERIV_GAIN     = 2'd2,
    REG_STOP_THRESHOLD = 2'd3
  } reg_idx_t;

  // Request kinds carried in s_tuser
  typedef enum logic [1:0] {
    ACT_ODOM = 2'd0,
    ACT_GOAL = 2'd1,
    ACT_TICK = 2'd2
  } action_t;

endpackage

/* hdl/heading_rotation_pid_top.sv */
// Heading rotation PID controller: input register, control step, result register.
//
//   Channel   Dir  Handshake                  Contents
//   s_*       in   s_tvalid / s_tready        tuser: action; tdata: yaw, goal rotation
//   m_*       out  m_tvalid / m_tready        tuser: stopping; tdata: angular speed
//   APB       in   psel & penable & pwrite    gains and stop threshold, 4-byte spaced
//
// One request is taken per cycle while s_tready is high; each is held in the input
// register, and its control step (wrap, error, PID multiplies, sum, round, saturate)
// completes into the result register when that register is free.
// Only a tick request yields a result; odometry and goal requests update state.
// A stalled result holds the step stage; the input register still takes one
// more request, then s_tready drops. Synchronous reset clears valid and controller state.
`include "heading_rotation_pid_top_assert.svh"

module heading_rotation_pid_top import hrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] measured_yaw, [32:16] goal_rotation
  input  logic [IN_USER_W-1:0]  s_tuser,   // [1:0] action
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [17:0] angular_speed
  output logic [OUT_USER_W-1:0] m_tuser,   // [0] stopping
  // Configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Constants at working widths
  localparam logic signed [ERR_W-1:0] PI_E     = ERR_W'(ANGLE_PI);
  localparam logic signed [ERR_W-1:0] NEG_PI_E = -ERR_W'(ANGLE_PI);
  localparam logic signed [ERR_W-1:0] TWO_PI_E = ERR_W'(ANGLE_2PI);
  localparam logic signed [ACC_W-1:0] ACC_RND =
    {{(ACC_W-GAIN_FRAC_BITS){1'b0}}, 1'b1, {(GAIN_FRAC_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SPD_MAX_A =
    {{(ACC_W-SPEED_W+1){1'b0}}, {(SPEED_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SPD_MIN_A =
    {{(ACC_W-SPEED_W+1){1'b1}}, {(SPEED_W-1){1'b0}}};

  // Configuration registers
  logic [GAIN_W-1:0] prop_gain;
  logic [GAIN_W-1:0] integ_gain;
  logic [GAIN_W-1:0] deriv_gain;
  logic [THR_W-1:0]  stop_threshold;

  // Controller state
  logic                     odom_seen;
  logic                     goal_pending;
  logic                     rotating;
  logic signed [YAW_W-1:0]  current_yaw;
  logic signed [YAW_W-1:0]  start_yaw;
  logic signed [GOAL_W-1:0] target_rotation;
  logic signed [SUM_W-1:0]  error_sum;
  logic signed [ERR_W-1:0]  last_error;

  // Input register
  logic                     in_valid;
  logic [1:0]               in_action;
  logic signed [YAW_W-1:0]  in_yaw;
  logic signed [GOAL_W-1:0] in_goal;

  // Result register
  logic                      out_valid;
  logic signed [SPEED_W-1:0] out_speed;
  logic                      out_stop;

  // Control step
  logic                           advance;
  logic                           fire;
  logic                           rot_eff;
  logic                           produce;
  logic                           above;
  logic signed [YAW_W-1:0]        start_eff;
  logic signed [SUM_W-1:0]        esum_eff;
  logic signed [ERR_W-1:0]        lerr_eff;
  logic signed [YAW_W:0]          done_raw;
  logic signed [ERR_W-1:0]        done_ext;
  logic signed [ERR_W-1:0]        done_wr;
  logic signed [ERR_W-1:0]        err;
  logic [ERR_W-1:0]               mag;
  logic signed [ERR_W:0]          deriv;
  logic signed [SUM_W:0]          sum_wide;
  logic signed [SUM_W-1:0]        sum_sat;
  logic signed [GAIN_W+ERR_W:0]   p_term;
  logic signed [GAIN_W+SUM_W:0]   i_term;
  logic signed [GAIN_W+ERR_W+1:0] d_term;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        acc_shr;
  logic signed [SPEED_W-1:0]      speed_next;

  logic cfg_wr;

  // Handshakes: the step stage moves whenever the result register is free
  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-SPEED_W){1'b0}}, out_speed};
  assign m_tuser  = out_stop;

  // APB access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_PROP_GAIN:      prdata = APB_DATA_W'(prop_gain);
      REG_INTEG_GAIN:     prdata = APB_DATA_W'(integ_gain);
      REG_DERIV_GAIN:     prdata = APB_DATA_W'(deriv_gain);
      REG_STOP_THRESHOLD: prdata = APB_DATA_W'(stop_threshold);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= PROP_GAIN_RST;
      integ_gain     <= INTEG_GAIN_RST;
      deriv_gain     <= DERIV_GAIN_RST;
      stop_threshold <= STOP_THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PROP_GAIN:      prop_gain      <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:     integ_gain     <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:     deriv_gain     <= pwdata[GAIN_W-1:0];
        REG_STOP_THRESHOLD: stop_threshold <= pwdata[THR_W-1:0];
        default:            ;
      endcase
    end
  end

  // Capture the next request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_yaw    <= s_tdata[YAW_W-1:0];
      in_goal   <= s_tdata[YAW_W+GOAL_W-1:YAW_W];
    end
  end

  // Control step: a pending goal restarts the rotation from the current yaw
  always_comb begin
    rot_eff   = goal_pending || rotating;
    produce   = (in_action == ACT_TICK) && odom_seen && rot_eff;
    start_eff = goal_pending ? current_yaw : start_yaw;
    esum_eff  = goal_pending ? '0 : error_sum;
    lerr_eff  = goal_pending ? '0 : last_error;

    // Rotation done, wrapped once into -pi..pi
    done_raw = (YAW_W+1)'(current_yaw) - (YAW_W+1)'(start_eff);
    done_ext = ERR_W'(done_raw);
    if (done_ext > PI_E) begin
      done_wr = done_ext - TWO_PI_E;
    end else if (done_ext < NEG_PI_E) begin
      done_wr = done_ext + TWO_PI_E;
    end else begin
      done_wr = done_ext;
    end

    // Error and stop decision
    err   = ERR_W'(target_rotation) - done_wr;
    mag   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    above = mag > ERR_W'(stop_threshold);

    // Derivative and saturated integral
    deriv    = (ERR_W+1)'(err) - (ERR_W+1)'(lerr_eff);
    sum_wide = (SUM_W+1)'(esum_eff) + (SUM_W+1)'(err);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end

    // Gain products, sum, round half up, saturate
    p_term  = $signed({1'b0, prop_gain}) * err;
    i_term  = $signed({1'b0, integ_gain}) * sum_sat;
    d_term  = $signed({1'b0, deriv_gain}) * deriv;
    acc     = ACC_W'(p_term) + ACC_W'(i_term) + ACC_W'(d_term) + ACC_RND;
    acc_shr = acc >>> GAIN_FRAC_BITS;
    if (acc_shr > SPD_MAX_A) begin
      speed_next = SPD_MAX_A[SPEED_W-1:0];
    end else if (acc_shr < SPD_MIN_A) begin
      speed_next = SPD_MIN_A[SPEED_W-1:0];
    end else begin
      speed_next = acc_shr[SPEED_W-1:0];
    end
  end

  // Update controller state as each request leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      odom_seen       <= 1'b0;
      goal_pending    <= 1'b0;
      rotating        <= 1'b0;
      current_yaw     <= '0;
      start_yaw       <= '0;
      target_rotation <= '0;
      error_sum       <= '0;
      last_error      <= '0;
    end else if (fire) begin
      case (in_action)
        ACT_ODOM: begin
          current_yaw <= in_yaw;
          odom_seen   <= 1'b1;
        end
        ACT_GOAL: begin
          target_rotation <= in_goal;
          goal_pending    <= 1'b1;
        end
        ACT_TICK: begin
          if (odom_seen) begin
            if (goal_pending) begin
              goal_pending <= 1'b0;
              start_yaw    <= current_yaw;
            end
            if (rot_eff) begin
              if (above) begin
                error_sum  <= sum_sat;
                last_error <= err;
                rotating   <= 1'b1;
              end else begin
                error_sum  <= esum_eff;
                last_error <= lerr_eff;
                rotating   <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register: load on a producing tick, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produce) begin
      out_speed <= above ? speed_next : '0;
      out_stop  <= !above;
    end
  end

  // Checks
  `HRP_ASSERT_IMP(a_stop_zero, clk, rst, out_valid && out_stop, out_speed == '0)
  `HRP_ASSERT_IMP(a_rot_needs_odom, clk, rst, rotating, odom_seen)
  `HRP_ASSERT_IMP(a_result_from_tick, clk, rst, fire && produce, in_action == ACT_TICK)
  `HRP_ASSERT_NXT(a_stop_ends_rot, clk, rst, fire && produce && !above, !rotating)
  `HRP_ASSERT_IMP(a_stall_only_full, clk, rst, !s_tready, in_valid && out_valid)

endmodule
